// ===== rtl/matmul_pkg.sv =====
// shared types, constants and helpers for the matrix multiply block
package matmul_pkg;

	// defaults for the top level parameters
	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;

	// configuration register file
	localparam int DIM_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

	// load counter and element totals (at most two 8x8 matrices)
	localparam int CNT_W = 7;
	localparam int TOT_W = 8;

	// row and column index of a result word
	localparam int POS_W = 3;

	// one product job handed from the loader to the compute engine
	typedef struct packed {
		logic             bank;
		logic [DIM_W-1:0] m;
		logic [DIM_W-1:0] kd;
		logic [DIM_W-1:0] n;
	} job_t;

	// store write strobes from the loader
	typedef struct packed {
		logic we_left;
		logic we_right;
		logic bank;
	} store_wr_t;

	// tags that travel with each multiply through the engine pipeline
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             lastk;
		logic             lastel;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pipe_tag_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_WAIT
	} back_state_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_dim) begin
			r = max_dim;
		end
		return r;
	endfunction

endpackage

// ===== rtl/matmul_queue.sv =====
// two-entry job queue between the loader and the compute engine
module matmul_queue
	import matmul_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head_job,
	output logic empty
);

	logic   [1:0] count_q;
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	job_t         entry_q [2];
	logic         full;

	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign head_job = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// the loader only pushes while a bank is free, so the queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

endmodule

// ===== rtl/matmul_front.sv =====
// loader: config registers, element counting, store writes and job hand-off
module matmul_front
	import matmul_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int FLAT_W     = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [DIM_W-1:0]      wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ELEM_WIDTH-1:0] element_value,
	output store_wr_t             st_wr,
	output logic [FLAT_W-1:0]     st_addr,
	output logic [ELEM_WIDTH-1:0] st_data,
	output logic                  job_push,
	output job_t                  job,
	input  logic                  job_done
);

	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] inner_q;
	logic [DIM_W-1:0] cols_q;
	logic [CNT_W-1:0] load_count_q;
	logic             bank_q;
	logic [1:0]       jobs_q;

	logic [DIM_W-1:0] m_c;
	logic [DIM_W-1:0] kd_c;
	logic [DIM_W-1:0] n_c;
	logic [TOT_W-1:0] na_c;
	logic [TOT_W-1:0] nb_c;
	logic [TOT_W-1:0] total_c;
	logic [TOT_W-1:0] idx_c;
	logic [TOT_W-1:0] flat_c;
	logic             is_left_c;
	logic             final_c;
	logic             accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROWS_A:    rows_q  <= wr_data;
				REG_INNER_DIM: inner_q <= wr_data;
				REG_COLS_B:    cols_q  <= wr_data;
				default:       ;
			endcase
		end
	end

	// dimensions and matrix sizes under the current registers
	always_comb begin
		m_c       = clamp_dim(rows_q, MAX_DIM_V);
		kd_c      = clamp_dim(inner_q, MAX_DIM_V);
		n_c       = clamp_dim(cols_q, MAX_DIM_V);
		na_c      = TOT_W'(m_c) * TOT_W'(kd_c);
		nb_c      = TOT_W'(kd_c) * TOT_W'(n_c);
		total_c   = na_c + nb_c;
		idx_c     = TOT_W'(load_count_q);
		is_left_c = (idx_c < na_c);
		flat_c    = is_left_c ? idx_c : (idx_c - na_c);
		final_c   = ((idx_c + TOT_W'(1)) >= total_c);
	end

	// both banks busy means two products still owed
	assign in_stall = (jobs_q == 2'd2);
	assign accept   = in_valid && !in_stall;

	// store write straight from the accepted word
	assign st_wr.we_left  = accept && is_left_c;
	assign st_wr.we_right = accept && !is_left_c;
	assign st_wr.bank     = bank_q;
	assign st_addr        = flat_c[FLAT_W-1:0];
	assign st_data        = element_value;

	// job for the engine once the last right element is in
	assign job_push = accept && final_c;
	assign job.bank = bank_q;
	assign job.m    = m_c;
	assign job.kd   = kd_c;
	assign job.n    = n_c;

	// load counter, bank select and outstanding jobs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			bank_q       <= 1'b0;
			jobs_q       <= 2'd0;
		end else begin
			if (accept) begin
				if (final_c) begin
					load_count_q <= '0;
					bank_q       <= ~bank_q;
				end else begin
					load_count_q <= load_count_q + CNT_W'(1);
				end
			end
			if (job_push && !job_done) begin
				jobs_q <= jobs_q + 2'd1;
			end else if (job_done && !job_push) begin
				jobs_q <= jobs_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/matmul_back.sv =====
// compute engine: operand stores, multiply-accumulate pipe and output register
module matmul_back
	import matmul_pkg::*;
#(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int FLAT_W     = 6,
	parameter int PROD_W     = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  store_wr_t             st_wr,
	input  logic [FLAT_W-1:0]     st_addr,
	input  logic [ELEM_WIDTH-1:0] st_data,
	input  logic                  job_valid,
	input  job_t                  job_in,
	output logic                  job_pop,
	output logic                  job_done,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PROD_W-1:0]     product_value,
	output logic [POS_W-1:0]      out_row,
	output logic [POS_W-1:0]      out_col,
	output logic                  last
);

	localparam int ADDR_W = FLAT_W + 1;
	localparam int MUL_W  = 2 * ELEM_WIDTH;

	// operand stores, one bank per job in flight
	logic [ELEM_WIDTH-1:0] left_mem  [2**ADDR_W];
	logic [ELEM_WIDTH-1:0] right_mem [2**ADDR_W];

	back_state_t state_q, state_d;
	job_t             job_q;
	logic [DIM_W-1:0] i_q;
	logic [DIM_W-1:0] j_q;
	logic [DIM_W-1:0] k_q;
	logic [FLAT_W-1:0] row_base_q;
	logic [FLAT_W-1:0] la_q;
	logic [FLAT_W-1:0] ra_q;

	logic                     rd_en;
	logic                     start;
	logic                     advance;
	logic                     lastk_c;
	logic                     lastel_c;
	logic                     row_end_c;
	logic [FLAT_W-1:0]        next_base_c;

	pipe_tag_t                tag_s1;
	pipe_tag_t                tag_s2;
	logic [ELEM_WIDTH-1:0]    a_s1;
	logic [ELEM_WIDTH-1:0]    b_s1;
	logic signed [MUL_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] acc_sum;

	logic                     res_pend_q;
	logic [POS_W-1:0]         res_row_q;
	logic [POS_W-1:0]         res_col_q;
	logic                     res_last_q;
	logic                     out_load;

	logic                     out_valid_q;
	logic [PROD_W-1:0]        product_q;
	logic [POS_W-1:0]         row_q;
	logic [POS_W-1:0]         col_q;
	logic                     last_q;

	// store writes from the loader, operand reads for the engine
	always_ff @(posedge clk) begin
		if (st_wr.we_left) begin
			left_mem[{st_wr.bank, st_addr}] <= st_data;
		end
		if (st_wr.we_right) begin
			right_mem[{st_wr.bank, st_addr}] <= st_data;
		end
		if (rd_en) begin
			a_s1 <= left_mem[{job_q.bank, la_q}];
			b_s1 <= right_mem[{job_q.bank, ra_q}];
		end
	end

	// position flags of the current element
	always_comb begin
		lastk_c     = (k_q == job_q.kd - DIM_W'(1));
		row_end_c   = (j_q == job_q.n - DIM_W'(1));
		lastel_c    = (i_q == job_q.m - DIM_W'(1)) && row_end_c;
		next_base_c = row_base_q + FLAT_W'(job_q.kd);
	end

	// result moves to the output register when that is free
	assign out_load = res_pend_q && (!out_valid_q || !out_stall);
	assign job_done = out_load && res_last_q;

	// sequencer: one result element at a time, inner loop one term a cycle
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		start   = 1'b0;
		advance = 1'b0;
		job_pop = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					start   = 1'b1;
					job_pop = 1'b1;
					state_d = BK_ISSUE;
				end
			end
			BK_ISSUE: begin
				rd_en = 1'b1;
				if (lastk_c) begin
					state_d = BK_WAIT;
				end
			end
			BK_WAIT: begin
				if (out_load) begin
					if (res_last_q) begin
						state_d = BK_IDLE;
					end else begin
						advance = 1'b1;
						state_d = BK_ISSUE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters and store addresses
	always_ff @(posedge clk) begin
		if (start) begin
			job_q      <= job_in;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			la_q       <= '0;
			ra_q       <= '0;
		end else if (rd_en) begin
			k_q  <= k_q + DIM_W'(1);
			la_q <= la_q + FLAT_W'(1);
			ra_q <= ra_q + FLAT_W'(job_q.n);
		end else if (advance) begin
			k_q <= '0;
			if (row_end_c) begin
				i_q        <= i_q + DIM_W'(1);
				j_q        <= '0;
				row_base_q <= next_base_c;
				la_q       <= next_base_c;
				ra_q       <= '0;
			end else begin
				j_q  <= j_q + DIM_W'(1);
				la_q <= row_base_q;
				ra_q <= FLAT_W'(j_q + DIM_W'(1));
			end
		end
	end

	// pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1.valid  <= rd_en;
			tag_s1.first  <= (k_q == '0);
			tag_s1.lastk  <= lastk_c;
			tag_s1.lastel <= lastel_c;
			tag_s1.row    <= i_q[POS_W-1:0];
			tag_s1.col    <= j_q[POS_W-1:0];
			tag_s2        <= tag_s1;
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			prod_s2 <= $signed(a_s1) * $signed(b_s1);
		end
	end

	// accumulate, exact in the full result width
	assign acc_sum = tag_s2.first ? PROD_W'(prod_s2) : (acc_q + PROD_W'(prod_s2));

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= acc_sum;
		end
		if (tag_s2.valid && tag_s2.lastk) begin
			res_row_q  <= tag_s2.row;
			res_col_q  <= tag_s2.col;
			res_last_q <= tag_s2.lastel;
		end
	end

	// finished sum waiting for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pend_q <= 1'b0;
		end else if (tag_s2.valid && tag_s2.lastk) begin
			res_pend_q <= 1'b1;
		end else if (out_load) begin
			res_pend_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			product_q <= acc_q;
			row_q     <= res_row_q;
			col_q     <= res_col_q;
			last_q    <= res_last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign product_value = product_q;
	assign out_row       = row_q;
	assign out_col       = col_q;
	assign last          = last_q;

	// a new sum never lands on top of one still waiting
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s2.valid && tag_s2.lastk) |-> !res_pend_q)
		else $error("accumulator result overrun");

	// an idle engine has nothing in flight
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_IDLE) |-> (!tag_s1.valid && !tag_s2.valid && !res_pend_q))
		else $error("engine idle with work in flight");

	// a job finishes only on the final element, and the engine then goes idle
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |=> (state_q == BK_IDLE) && out_valid_q && last_q)
		else $error("job end not followed by idle engine");

endmodule

// ===== rtl/matrix_multiply.sv =====
// Streaming matrix multiply C = A * B on signed Q8.8 words with exact Q20.16 results.
// Words of A and then B arrive one per cycle while the input is not stalled, in
// row-major order, and are written into one of two operand banks, so the next pair
// of matrices can load while the current product is computed. Once the last word
// of B is taken, the engine emits C in row-major order, one result word at a time
// from the single multiply-accumulate unit reading one term per cycle from the
// operand stores; an output stall holds the engine until the waiting word moves
// on. The input stalls while both banks hold products not yet fully delivered.
// Dimension registers of 0 act as 1, values above MAX_DIM act as MAX_DIM.
module matrix_multiply
	import matmul_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         wr_en,
	input  logic [CFG_IDX_W-1:0]                         wr_index,
	input  logic [DIM_W-1:0]                             wr_data,
	input  logic                                         in_valid,
	output logic                                         in_stall,
	input  logic [ELEM_WIDTH-1:0]                        element_value,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic [2*ELEM_WIDTH+$clog2(MAX_DIM)+1-1:0]    product_value,
	output logic [POS_W-1:0]                             out_row,
	output logic [POS_W-1:0]                             out_col,
	output logic                                         last
);

	localparam int FLAT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
	localparam int PROD_W = 2 * ELEM_WIDTH + $clog2(MAX_DIM) + 1;

	store_wr_t             st_wr;
	logic [FLAT_W-1:0]     st_addr;
	logic [ELEM_WIDTH-1:0] st_data;
	logic                  job_push;
	job_t                  push_job;
	job_t                  head_job;
	logic                  job_pop;
	logic                  job_done;
	logic                  q_empty;

	// loader
	matmul_front #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH),
		.FLAT_W     (FLAT_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.st_wr         (st_wr),
		.st_addr       (st_addr),
		.st_data       (st_data),
		.job_push      (job_push),
		.job           (push_job),
		.job_done      (job_done)
	);

	// job hand-off
	matmul_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	// compute engine
	matmul_back #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FLAT_W     (FLAT_W),
		.PROD_W     (PROD_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.st_wr         (st_wr),
		.st_addr       (st_addr),
		.st_data       (st_data),
		.job_valid     (!q_empty),
		.job_in        (head_job),
		.job_pop       (job_pop),
		.job_done      (job_done),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_value (product_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.last          (last)
	);

endmodule
